// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define PTPN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ptpn assertion failed");

// Check a property on every rising clock edge, reset included.
`define PTPN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ptpn assertion failed");

`endif

// ===== rtl/core/ptpn_pkg.sv =====
// Types and constants for the planar tile to packed nibble converter.
package ptpn_pkg;

    localparam int TILES_PER_SHEET_DEF = 64;
    localparam int SHEET_OUT_BYTES_DEF = 2048;

    localparam int TILE_BYTES_2BPP = 16;
    localparam int TILE_BYTES_3BPP = 24;
    localparam int PLANE2_OFFSET   = 16;
    localparam int ROWS_PER_TILE   = 8;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 19;
    localparam int ROW_W     = 3;
    localparam int OFF16_W   = 4;
    localparam int OFF24_W   = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THREE_BPP    = 1'b0,
        REG_SHEET_NUMBER = 1'b1
    } t_cfg_reg;

    // One completed pixel row: three planes and the raster address of its first byte
    typedef struct packed {
        logic [BYTE_W-1:0] p0;
        logic [BYTE_W-1:0] p1;
        logic [BYTE_W-1:0] p2;
        logic [ADDR_W-1:0] addr;
    } t_row;

endpackage

// ===== rtl/core/ptpn_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ptpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ptpn_row_ser.sv =====
// Output serializer: turns one pixel row into four packed pixel bytes.
module ptpn_row_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  ptpn_pkg::t_row               i_row,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [ptpn_pkg::BYTE_W-1:0]  o_packed,
    output logic [ptpn_pkg::ADDR_W-1:0]  o_addr,
    output logic                         o_last,
    output logic                         o_free
);

    logic                        r_valid;
    logic [1:0]                  r_x;
    logic [ptpn_pkg::BYTE_W-1:0] r_p0, r_p1, r_p2;
    logic [ptpn_pkg::ADDR_W-1:0] r_addr;
    logic                        w_take;

    assign w_take = r_valid && i_ready;
    assign o_free = !r_valid || (i_ready && (r_x == 2'd3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_x     <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_x     <= 2'd0;
        end else if (w_take) begin
            r_valid <= (r_x != 2'd3);
            r_x     <= r_x + 2'd1;
        end
    end

    // Shift the planes left by one pixel pair per item
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p0   <= i_row.p0;
            r_p1   <= i_row.p1;
            r_p2   <= i_row.p2;
            r_addr <= i_row.addr;
        end else if (w_take) begin
            r_p0   <= {r_p0[ptpn_pkg::BYTE_W-3:0], 2'b00};
            r_p1   <= {r_p1[ptpn_pkg::BYTE_W-3:0], 2'b00};
            r_p2   <= {r_p2[ptpn_pkg::BYTE_W-3:0], 2'b00};
            r_addr <= r_addr + ptpn_pkg::ADDR_W'(1);
        end
    end

    assign o_valid  = r_valid;
    assign o_packed = {1'b0, r_p2[7], r_p1[7], r_p0[7], 1'b0, r_p2[6], r_p1[6], r_p0[6]};
    assign o_addr   = r_addr;
    assign o_last   = (r_x == 2'd3);

endmodule

// ===== rtl/core/planar_tile_to_packed_nibbles.sv =====
// Planar 2bpp/3bpp tile sheet to packed 4-bit pixel converter, top level.
//
// Takes one planar byte per item and gives four packed pixel bytes for each byte that
// completes a pixel row, one per cycle while the receiver is ready, the last with tlast
// set. A byte is accepted in every cycle while no completed row waits; the completing
// byte and the plane store read are registered in the read stage, and the row is loaded
// into the serializer once it is free. The output serializer sets the sustained rate
// of row-completing bytes, other bytes at one per cycle. Planes 0 and 1 sit
// in two 8-entry banks indexed by pixel row. Byte position is kept as tile/offset pairs
// for both tile sizes, so a mode change between sheets takes effect at once. There is
// no clearing pass after reset; bytes past the last tile are dropped until tuser marks
// a new sheet.
module planar_tile_to_packed_nibbles #(
    parameter int TILES_PER_SHEET = ptpn_pkg::TILES_PER_SHEET_DEF,
    parameter int SHEET_OUT_BYTES = ptpn_pkg::SHEET_OUT_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] plane_byte
    input  logic                           s_axis_tuser,  // [0] sheet_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // [7:0] packed_pixels,
                                                          // [26:8] pixel_address
    output logic                           m_axis_tlast,  // run_last
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptpn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    localparam int TW = $clog2(2 * TILES_PER_SHEET);
    localparam int CW = $clog2(TILES_PER_SHEET * ptpn_pkg::TILE_BYTES_3BPP + 1);
    localparam int AW = ptpn_pkg::ADDR_W;

    // Configuration
    logic          r_three;
    logic [AW-1:0] r_base;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three <= 1'b0;
            r_base  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptpn_pkg::REG_THREE_BPP:    r_three <= i_cfg_data[0];
                ptpn_pkg::REG_SHEET_NUMBER:
                    r_base <= AW'(32'(i_cfg_data) * 32'(SHEET_OUT_BYTES));
                default: ;
            endcase
        end
    end

    // Byte position, tracked as tile and offset for both tile sizes
    logic [TW-1:0]                r_tile16, r_tile24, w_tile16, w_tile24, w_tile;
    logic [ptpn_pkg::OFF16_W-1:0] r_off16, w_off16;
    logic [ptpn_pkg::OFF24_W-1:0] r_off24, w_off24;
    logic [ptpn_pkg::OFF24_W-1:0] w_off;
    logic                         w_accept, w_act, w_plane2, w_emit, w_load, w_free;
    logic [ptpn_pkg::ROW_W-1:0]   w_y;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_tile16 = s_axis_tuser ? '0 : r_tile16;
        w_tile24 = s_axis_tuser ? '0 : r_tile24;
        w_off16  = s_axis_tuser ? '0 : r_off16;
        w_off24  = s_axis_tuser ? '0 : r_off24;
        w_tile   = r_three ? w_tile24 : w_tile16;
        w_off    = r_three ? w_off24 : ptpn_pkg::OFF24_W'(w_off16);
        w_act    = w_accept && (w_tile < TW'(TILES_PER_SHEET));
        w_plane2 = r_three && (w_off24 >= ptpn_pkg::OFF24_W'(ptpn_pkg::PLANE2_OFFSET));
        w_emit   = w_act && (w_plane2 || (!r_three && w_off16[0]));
        w_y      = w_plane2 ? w_off24[ptpn_pkg::ROW_W-1:0] : w_off[ptpn_pkg::ROW_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile16 <= '0;
            r_tile24 <= '0;
            r_off16  <= '0;
            r_off24  <= '0;
        end else if (w_act) begin
            r_off16 <= w_off16 + ptpn_pkg::OFF16_W'(1);
            if (w_off16 == ptpn_pkg::OFF16_W'(ptpn_pkg::TILE_BYTES_2BPP - 1)) begin
                r_tile16 <= w_tile16 + TW'(1);
            end else begin
                r_tile16 <= w_tile16;
            end
            if (w_off24 == ptpn_pkg::OFF24_W'(ptpn_pkg::TILE_BYTES_3BPP - 1)) begin
                r_off24  <= '0;
                r_tile24 <= w_tile24 + TW'(1);
            end else begin
                r_off24  <= w_off24 + ptpn_pkg::OFF24_W'(1);
                r_tile24 <= w_tile24;
            end
        end else if (w_accept) begin
            // Past the last tile: only a sheet start moves the position
            r_tile16 <= w_tile16;
            r_tile24 <= w_tile24;
            r_off16  <= w_off16;
            r_off24  <= w_off24;
        end
    end

    // Plane store: bank 0 holds plane 0, bank 1 holds plane 1, by pixel row
    logic [7:0] w_rd0, w_rd1;
    logic       w_we0, w_we1;

    assign w_we0 = w_act && !w_plane2 && !w_off[0];
    assign w_we1 = w_act && !w_plane2 && w_off[0];

    ptpn_ram #(.WIDTH(ptpn_pkg::BYTE_W), .DEPTH(ptpn_pkg::ROWS_PER_TILE)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_y),
        .i_wdata (s_axis_tdata),
        .i_re    (w_emit),
        .i_raddr (w_y),
        .o_rdata (w_rd0)
    );

    ptpn_ram #(.WIDTH(ptpn_pkg::BYTE_W), .DEPTH(ptpn_pkg::ROWS_PER_TILE)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_y),
        .i_wdata (s_axis_tdata),
        .i_re    (w_emit),
        .i_raddr (w_y),
        .o_rdata (w_rd1)
    );

    // Read stage: hold the completing byte while the store read lands
    logic                       r_s1v, r_s1_three;
    logic [7:0]                 r_s1_byte;
    logic [ptpn_pkg::ROW_W-1:0] r_s1_y;
    logic [TW-1:0]              r_s1_tile;

    assign w_load        = r_s1v && w_free;
    assign s_axis_tready = !r_s1v || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (w_emit) begin
            r_s1v <= 1'b1;
        end else if (w_load) begin
            r_s1v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_byte  <= s_axis_tdata;
            r_s1_three <= r_three;
            r_s1_y     <= w_y;
            r_s1_tile  <= w_tile;
        end
    end

    ptpn_pkg::t_row w_row;
    logic [AW-1:0]  w_tile_ext;

    always_comb begin
        w_tile_ext = AW'(r_s1_tile);
        w_row.p0   = w_rd0;
        w_row.p1   = r_s1_three ? w_rd1 : r_s1_byte;
        w_row.p2   = r_s1_three ? r_s1_byte : '0;
        w_row.addr = r_base + ((w_tile_ext >> 4) << 9) + (AW'(r_s1_y) << 6)
                   + (AW'(w_tile_ext[3:0]) << 2);
    end

    logic [7:0]    w_packed;
    logic [AW-1:0] w_addr;

    ptpn_row_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_row    (w_row),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_packed (w_packed),
        .o_addr   (w_addr),
        .o_last   (m_axis_tlast),
        .o_free   (w_free)
    );

    assign m_axis_tdata = {5'b0, w_addr, w_packed};

    // Byte position as seen through each tile size
    logic [CW-1:0] w_pos16, w_pos24;
    logic          w_s1_wait;

    assign w_pos16   = CW'(r_tile16) * CW'(ptpn_pkg::TILE_BYTES_2BPP) + CW'(r_off16);
    assign w_pos24   = CW'(r_tile24) * CW'(ptpn_pkg::TILE_BYTES_3BPP) + CW'(r_off24);
    assign w_s1_wait = r_s1v && !w_load;

`include "assert_macros.svh"

    `PTPN_ASSERT(a_pos_agree, i_clk, i_rst_n, w_pos16 == w_pos24)
    `PTPN_ASSERT(a_tile_bound, i_clk, i_rst_n, r_tile24 <= TW'(TILES_PER_SHEET))
    `PTPN_ASSERT(a_s1_hold, i_clk, i_rst_n, w_s1_wait |=> r_s1v && $stable(r_s1_tile))

endmodule

// ===== verif/planar_tile_to_packed_nibbles_test.sv =====
// Self-checking testbench for the planar tile to packed nibble converter.
module planar_tile_to_packed_nibbles_test;
    import ptpn_pkg::*;

    localparam int TILES_ACROSS = 16;
    localparam int LINE_BYTES   = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0]  pixels;
        logic [18:0] addr;
        logic        row_end;
    } pixel_byte_t;

    // Tracks plane bytes and sheet position, queues the pixel bytes each row yields.
    class nibble_scoreboard;
        logic [7:0]  plane_mem [16];
        int unsigned sheet_pos;
        bit          mode_3bpp;
        logic [7:0]  sheet_idx;
        pixel_byte_t pixel_bytes_due [$];
        int unsigned errors;

        function void set_reg(t_cfg_reg idx, logic [7:0] val);
            if (idx == REG_THREE_BPP) begin
                mode_3bpp = val[0];
            end else begin
                sheet_idx = val;
            end
        endfunction

        function void queue_row(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                                int unsigned tile, int unsigned y);
            pixel_byte_t pb;
            int unsigned raw;
            int k;
            for (int x = 0; x < 4; x++) begin
                k = 7 - 2 * x;
                pb.pixels = {1'b0, p2[k], p1[k], p0[k], 1'b0, p2[k-1], p1[k-1], p0[k-1]};
                raw = int'(sheet_idx) * SHEET_OUT_BYTES_DEF
                    + (tile / TILES_ACROSS) * ROWS_PER_TILE * LINE_BYTES
                    + y * LINE_BYTES + (tile % TILES_ACROSS) * 4 + x;
                pb.addr    = raw[18:0];
                pb.row_end = (x == 3);
                pixel_bytes_due.push_back(pb);
            end
        endfunction

        function void take_plane_byte(logic [7:0] b, logic start);
            int unsigned tile_size;
            int unsigned offs;
            int unsigned tile;
            int unsigned y;
            tile_size = mode_3bpp ? TILE_BYTES_3BPP : TILE_BYTES_2BPP;
            if (start) sheet_pos = 0;
            // drop bytes past the last tile of the sheet
            if (sheet_pos >= TILES_PER_SHEET_DEF * tile_size) return;
            offs = sheet_pos % tile_size;
            tile = sheet_pos / tile_size;
            sheet_pos++;
            if (offs < PLANE2_OFFSET) begin
                plane_mem[offs] = b;
                if (!mode_3bpp && offs[0])
                    queue_row(plane_mem[offs-1], b, 8'h00, tile, offs / 2);
            end else begin
                y = offs - PLANE2_OFFSET;
                queue_row(plane_mem[2*y], plane_mem[2*y+1], b, tile, y);
            end
        endfunction

        function void mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        endfunction

        function void check_pixel_byte(logic [31:0] data, logic last);
            pixel_byte_t want;
            if (pixel_bytes_due.size() == 0) begin
                mismatch("unexpected item, nothing pending; data", 32'h0, data);
                return;
            end
            want = pixel_bytes_due.pop_front();
            if (data[7:0] !== want.pixels)
                mismatch("packed pixels", 32'(want.pixels), 32'(data[7:0]));
            if (data[26:8] !== want.addr)
                mismatch("pixel address", 32'(want.addr), 32'(data[26:8]));
            if (last !== want.row_end)
                mismatch("row end flag", 32'(want.row_end), 32'(last));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    nibble_scoreboard sb = new();
    bit               calm = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      cycle_count = 0;

    // one 2bpp tile: blank, full, single-plane rows, alternating bits, end pixels
    logic [7:0] pattern_tile [16] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF,
                                      8'hAA, 8'h55, 8'h80, 8'h01, 8'h0F, 8'hF0, 8'h5A, 8'hC3};

    planar_tile_to_packed_nibbles uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel_byte(m_axis_tdata, m_axis_tlast);
    end

    initial begin : sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = calm || ($urandom_range(99) >= 7);
        end
    end

    // Entered and left at a falling edge; tvalid stays high for a following item.
    task automatic push_byte(input logic [7:0] b, input logic start);
        while (!calm && $urandom_range(99) < 7) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = start;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_plane_byte(b, start);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pixel_bytes_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Random bytes, a sheet start up front when fresh, and a stray one now and then.
    task automatic send_run(input int unsigned len, input bit fresh);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom), (i == 0 && fresh) || $urandom_range(99) < 3);
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned len;
        bit          fresh;
        logic [7:0]  mode_val;
        logic [7:0]  sheet_val;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_THREE_BPP;
        i_cfg_data    = 8'h00;
        i_rst_n       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // top sheet number, the highest raster address base
        write_reg(REG_THREE_BPP, 8'h00);
        write_reg(REG_SHEET_NUMBER, 8'hFF);
        foreach (pattern_tile[i]) push_byte(pattern_tile[i], i == 0);
        drain();

        // go to 3bpp mid-sheet: the count carries on into the plane 2 bytes
        write_reg(REG_THREE_BPP, 8'h01);
        write_reg(REG_SHEET_NUMBER, 8'h00);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h3C, 1'b1);

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            mode_val  = 8'($urandom);
            sheet_val = 8'($urandom);
            // 2bpp while the receiver holds off, so rows pile up and stall the input
            if (ph == 2 || ph == 3) mode_val[0] = 1'b0;
            if (ph == 6) mode_val[0] = 1'b1;
            if (ph == 1) sheet_val = 8'h00;
            if (ph == 2) sheet_val = 8'hFF;
            write_reg(REG_THREE_BPP, mode_val);
            write_reg(REG_SHEET_NUMBER, sheet_val);
            fresh = (ph == 3) || (ph == 6) || ($urandom_range(3) != 0);
            if (ph == 2) hold_req = 1'b1;
            if (ph == 3 || ph == 6) begin
                // a few whole tiles from a sheet start
                calm = (ph == 3);
                n = (ph == 3) ? 3 * TILE_BYTES_2BPP : 2 * TILE_BYTES_3BPP;
                for (int i = 0; i < n; i++) push_byte(8'($urandom), i == 0);
                calm = 1'b0;
            end else begin
                n = 0;
                while (n < 10) begin
                    len = $urandom_range(12, 4);
                    send_run(len, n > 0 || fresh);
                    n += len;
                end
            end
        end
        drain();

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
